FILE: hw/rtl/ndis_pkg.sv
package ndis_pkg;

    // fixed-point formats
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int GAIN_FRAC_BITS  = 8;

    // angle constants at 16 and 17 fractional bits, scaled down to the angle format
    localparam int DEG85_Q16 = 97224;
    localparam int DEG95_Q16 = 108662;
    localparam int PI_Q17    = 411774;
    localparam int T85       = DEG85_Q16 >> (16 - ANGLE_FRAC_BITS);
    localparam int T95       = DEG95_Q16 >> (16 - ANGLE_FRAC_BITS);
    localparam int PI_Q      = ((PI_Q17 >> (16 - ANGLE_FRAC_BITS)) + 1) >> 1;

    // field widths
    localparam int ERR_W  = 16;
    localparam int GAIN_W = 20;
    localparam int PTR_W  = 8;
    localparam int LIM_W  = 7;
    localparam int CFG_IDX_W = 2;

    // internal widths: error after folding, product, target
    localparam int PI_W   = $clog2(PI_Q + 1) + 1;
    localparam int EXT_W  = ((ERR_W > PI_W) ? ERR_W : PI_W) + 1;
    localparam int SHIFT  = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
    localparam int PROD_W = EXT_W + GAIN_W;
    localparam int TGT_W  = PROD_W - SHIFT + 1;

    localparam logic signed [EXT_W-1:0] T85_S = EXT_W'(T85);
    localparam logic signed [EXT_W-1:0] T95_S = EXT_W'(T95);
    localparam logic signed [EXT_W-1:0] PI_S  = EXT_W'(PI_Q);

    // register reset values
    localparam logic [GAIN_W-1:0] ILS_COURSE_GAIN_RST = GAIN_W'(352025);
    localparam logic [GAIN_W-1:0] ILS_SLOPE_GAIN_RST  = GAIN_W'(314308);
    localparam logic [GAIN_W-1:0] VOR_COURSE_GAIN_RST = GAIN_W'(88006);
    localparam logic [LIM_W-1:0]  POINTER_LIMIT_RST   = LIM_W'(60);

    typedef enum logic [1:0] {
        FLAG_NONE = 2'd0,
        FLAG_OFF  = 2'd1,
        FLAG_TO   = 2'd2,
        FLAG_FROM = 2'd3
    } t_dir_flag;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ILS_COURSE_GAIN = 2'd0,
        REG_ILS_SLOPE_GAIN  = 2'd1,
        REG_VOR_COURSE_GAIN = 2'd2,
        REG_POINTER_LIMIT   = 2'd3
    } t_cfg_reg;

    // sign * ((|e| * gain) >> SHIFT), truncates toward zero
    function automatic logic signed [TGT_W-1:0] apply_gain(
        input logic signed [EXT_W-1:0] e,
        input logic        [GAIN_W-1:0] gain
    );
        logic [EXT_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        logic [TGT_W-1:0]  res;
        mag  = e[EXT_W-1] ? EXT_W'(-e) : EXT_W'(e);
        prod = PROD_W'(mag) * PROD_W'(gain);
        res  = TGT_W'(prod >> SHIFT);
        return e[EXT_W-1] ? $signed(-res) : $signed(res);
    endfunction

endpackage

FILE: hw/rtl/ndis_slew.sv
module ndis_slew (
    input  logic signed [ndis_pkg::TGT_W-1:0] i_target,
    input  logic signed [ndis_pkg::PTR_W-1:0] i_old,
    input  logic        [ndis_pkg::LIM_W-1:0] i_limit,
    output logic signed [ndis_pkg::PTR_W-1:0] o_ptr
);

    localparam int TW = ndis_pkg::TGT_W;
    localparam int PW = ndis_pkg::PTR_W;
    localparam int LW = ndis_pkg::LIM_W;

    logic signed [TW-1:0] old_ext;
    logic signed [PW:0]   old_w;
    logic signed [PW:0]   step;
    logic signed [PW:0]   lim_pos;
    logic signed [PW:0]   lim_neg;
    logic signed [PW:0]   clamped;

    assign old_ext = {{(TW - PW){i_old[PW-1]}}, i_old};
    assign old_w   = {i_old[PW-1], i_old};
    assign lim_pos = $signed({{(PW + 1 - LW){1'b0}}, i_limit});
    assign lim_neg = -lim_pos;

    // one pixel toward the target
    always_comb begin
        if (i_target > old_ext) begin
            step = old_w + (PW+1)'(1);
        end else if (i_target < old_ext) begin
            step = old_w - (PW+1)'(1);
        end else begin
            step = old_w;
        end
    end

    // saturate at the configured bound
    always_comb begin
        if (step > lim_pos) begin
            clamped = lim_pos;
        end else if (step < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = step;
        end
    end

    assign o_ptr = clamped[PW-1:0];

endmodule

FILE: hw/rtl/nav_deviation_indicator_slew.sv
// An accepted input word passes through stage 1 and then the output register.
// Throughput: one word per cycle while the output is not stalled; stage 1 holds the
// gain products, stage 2 the slewed pointers, and the output register doubles as the pointer state.
// Reset (synchronous, active low): gains and limit to defaults, both pointers
// to zero, pipeline empty.
module nav_deviation_indicator_slew (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // bearing_error[15:0], slope_error[31:16]
    input  logic [1:0]  s_axis_tuser,   // ils_mode[0], receiver_valid[1]
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // course_pointer[7:0], slope_pointer[15:8]
    output logic [3:0]  m_axis_tuser,   // direction_flag[1:0], nav_valid[2], slope_valid[3]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ndis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ndis_pkg::GAIN_W-1:0]    i_cfg_data
);

    localparam int EW = ndis_pkg::EXT_W;
    localparam int TW = ndis_pkg::TGT_W;
    localparam int PW = ndis_pkg::PTR_W;
    localparam int GW = ndis_pkg::GAIN_W;
    localparam int LW = ndis_pkg::LIM_W;
    localparam int RW = ndis_pkg::ERR_W;

    // configuration registers
    logic [GW-1:0] r_ils_course_gain;
    logic [GW-1:0] r_ils_slope_gain;
    logic [GW-1:0] r_vor_course_gain;
    logic [LW-1:0] r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ils_course_gain <= ndis_pkg::ILS_COURSE_GAIN_RST;
            r_ils_slope_gain  <= ndis_pkg::ILS_SLOPE_GAIN_RST;
            r_vor_course_gain <= ndis_pkg::VOR_COURSE_GAIN_RST;
            r_limit           <= ndis_pkg::POINTER_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (ndis_pkg::t_cfg_reg'(i_cfg_index))
                ndis_pkg::REG_ILS_COURSE_GAIN: r_ils_course_gain <= i_cfg_data;
                ndis_pkg::REG_ILS_SLOPE_GAIN:  r_ils_slope_gain  <= i_cfg_data;
                ndis_pkg::REG_VOR_COURSE_GAIN: r_vor_course_gain <= i_cfg_data;
                ndis_pkg::REG_POINTER_LIMIT:   r_limit           <= i_cfg_data[LW-1:0];
            endcase
        end
    end

    // pipeline handshake
    logic r_s1_vld;
    logic r_out_vld;
    logic out_free;
    logic s1_adv;
    logic in_acc;

    assign out_free      = !r_out_vld || m_axis_tready;
    assign s1_adv        = r_s1_vld && out_free;
    assign s_axis_tready = !r_s1_vld || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // unpack input word
    logic signed [EW-1:0] bearing;
    logic signed [EW-1:0] slope;
    logic                 ils;
    logic                 rx_valid;

    assign bearing  = EW'($signed(s_axis_tdata[RW-1:0]));
    assign slope    = EW'($signed(s_axis_tdata[2*RW-1:RW]));
    assign ils      = s_axis_tuser[0];
    assign rx_valid = s_axis_tuser[1];

    // VOR sector: TO within 85 deg, FROM beyond 95 deg with fold about +/-pi
    logic signed [EW-1:0] vor_err;
    ndis_pkg::t_dir_flag  vor_flag;

    always_comb begin
        vor_err  = bearing;
        vor_flag = ndis_pkg::FLAG_OFF;
        if (bearing >= -ndis_pkg::T85_S && bearing <= ndis_pkg::T85_S) begin
            vor_flag = ndis_pkg::FLAG_TO;
        end else if (bearing < -ndis_pkg::T95_S) begin
            vor_err  = -ndis_pkg::PI_S - bearing;
            vor_flag = ndis_pkg::FLAG_FROM;
        end else if (bearing > ndis_pkg::T95_S) begin
            vor_err  = ndis_pkg::PI_S - bearing;
            vor_flag = ndis_pkg::FLAG_FROM;
        end
    end

    // targets and flag for stage 1
    logic signed [EW-1:0] course_err;
    logic [GW-1:0]        course_gain;
    logic signed [TW-1:0] n_course_tgt;
    logic signed [TW-1:0] n_slope_tgt;
    ndis_pkg::t_dir_flag  n_flag;

    assign course_err  = ils ? bearing : vor_err;
    assign course_gain = ils ? r_ils_course_gain : r_vor_course_gain;

    always_comb begin
        n_course_tgt = '0;
        n_slope_tgt  = '0;
        n_flag       = ndis_pkg::FLAG_OFF;
        if (rx_valid) begin
            n_course_tgt = ndis_pkg::apply_gain(course_err, course_gain);
            if (ils) begin
                n_slope_tgt = ndis_pkg::apply_gain(slope, r_ils_slope_gain);
                n_flag      = ndis_pkg::FLAG_NONE;
            end else begin
                n_flag = vor_flag;
            end
        end
    end

    // stage 1 registers
    logic signed [TW-1:0] r_course_tgt;
    logic signed [TW-1:0] r_slope_tgt;
    ndis_pkg::t_dir_flag  r_s1_flag;
    logic                 r_s1_nav;
    logic                 r_s1_gs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_course_tgt <= n_course_tgt;
            r_slope_tgt  <= n_slope_tgt;
            r_s1_flag    <= n_flag;
            r_s1_nav     <= rx_valid;
            r_s1_gs      <= rx_valid && ils;
        end
    end

    // slew toward the targets from the current pointers
    logic signed [PW-1:0] r_course_ptr;
    logic signed [PW-1:0] r_slope_ptr;
    logic signed [PW-1:0] n_course_ptr;
    logic signed [PW-1:0] n_slope_ptr;

    ndis_slew u_course_slew (
        .i_target (r_course_tgt),
        .i_old    (r_course_ptr),
        .i_limit  (r_limit),
        .o_ptr    (n_course_ptr)
    );

    ndis_slew u_slope_slew (
        .i_target (r_slope_tgt),
        .i_old    (r_slope_ptr),
        .i_limit  (r_limit),
        .o_ptr    (n_slope_ptr)
    );

    // output register, pointers also serve as the slew state
    ndis_pkg::t_dir_flag r_out_flag;
    logic                r_out_nav;
    logic                r_out_gs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld    <= 1'b0;
            r_course_ptr <= '0;
            r_slope_ptr  <= '0;
        end else begin
            if (s1_adv) begin
                r_out_vld    <= 1'b1;
                r_course_ptr <= n_course_ptr;
                r_slope_ptr  <= n_slope_ptr;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_flag <= r_s1_flag;
            r_out_nav  <= r_s1_nav;
            r_out_gs   <= r_s1_gs;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_slope_ptr, r_course_ptr};
    assign m_axis_tuser  = {r_out_gs, r_out_nav, r_out_flag};

    // checks
    logic signed [PW:0] course_ext;
    logic signed [PW:0] slope_ext;
    logic signed [PW:0] lim_ext;

    assign course_ext = {r_course_ptr[PW-1], r_course_ptr};
    assign slope_ext  = {r_slope_ptr[PW-1], r_slope_ptr};
    assign lim_ext    = $signed({{(PW + 1 - LW){1'b0}}, r_limit});

    // each pointer moves by one step; a pointer left outside a lowered limit snaps onto the limit
    a_course_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $stable(r_limit) && !$stable(r_course_ptr) |->
            (course_ext - $past(course_ext) == (PW+1)'(1)) ||
            (course_ext - $past(course_ext) == -(PW+1)'(1)) ||
            (course_ext == lim_ext) || (course_ext == -lim_ext))
        else $error("course pointer moved more than one step");

    a_slope_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $stable(r_limit) && !$stable(r_slope_ptr) |->
            (slope_ext - $past(slope_ext) == (PW+1)'(1)) ||
            (slope_ext - $past(slope_ext) == -(PW+1)'(1)) ||
            (slope_ext == lim_ext) || (slope_ext == -lim_ext))
        else $error("slope pointer moved more than one step");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !out_free |=> r_s1_vld)
        else $error("stage 1 word lost while output stalled");

    a_flag_none_ils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_flag == ndis_pkg::FLAG_NONE |-> r_out_gs && r_out_nav)
        else $error("NONE flag without valid ILS reception");

endmodule

FILE: tb/sv/ndis_pointer_checker.sv
// Watches the input, output and configuration channels of the deviation
// indicator, keeps its own copy of the gains, limit and pointer state, and
// compares each output word with the oldest predicted indication.
module ndis_pointer_checker
    import ndis_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // bearing_error[15:0], slope_error[31:16]
    input  logic [1:0]           s_axis_tuser,   // ils_mode[0], receiver_valid[1]
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [15:0]          m_axis_tdata,   // course_pointer[7:0], slope_pointer[15:8]
    input  logic [3:0]           m_axis_tuser,   // direction_flag[1:0], nav_valid[2], slope_valid[3]
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [PTR_W-1:0] course;
        logic signed [PTR_W-1:0] slope;
        t_dir_flag               flag;
        logic                    nav_ok;
        logic                    gs_ok;
    } t_indication;

    // local copy of the registers and pointer state
    logic [GAIN_W-1:0] loc_gain;
    logic [GAIN_W-1:0] gs_gain;
    logic [GAIN_W-1:0] vor_gain;
    logic [LIM_W-1:0]  ptr_lim;
    int                course_last;
    int                slope_last;
    int                mismatches = 0;
    t_indication       due_indications[$];

    // error times gain, truncated toward zero
    function automatic longint scaled_deflection(input longint err, input logic [GAIN_W-1:0] gain);
        longint mag;
        longint g;
        g   = gain;
        mag = (err < 0) ? -err : err;
        mag = (mag * g) >>> (ANGLE_FRAC_BITS + GAIN_FRAC_BITS);
        return (err < 0) ? -mag : mag;
    endfunction

    // one pixel toward the target, then clamp at the limit
    function automatic int slew_toward(input longint target, input int prev);
        int v;
        int lim;
        lim = int'(ptr_lim);
        v   = prev;
        if (target > prev) begin
            v = prev + 1;
        end else if (target < prev) begin
            v = prev - 1;
        end
        if (v > lim) begin
            v = lim;
        end else if (v < -lim) begin
            v = -lim;
        end
        return v;
    endfunction

    // predicted indication for one input word; advances the pointer state
    function automatic t_indication next_indication(input logic [15:0] b_raw,
                                                    input logic [15:0] s_raw,
                                                    input logic ils, input logic rx_ok);
        longint      brg;
        longint      slp;
        longint      course_tgt;
        longint      slope_tgt;
        t_indication r;
        brg        = $signed(b_raw);
        slp        = $signed(s_raw);
        course_tgt = 0;
        slope_tgt  = 0;
        r.flag     = FLAG_OFF;
        if (ils) begin
            if (rx_ok) begin
                r.flag     = FLAG_NONE;
                course_tgt = scaled_deflection(brg, loc_gain);
                slope_tgt  = scaled_deflection(slp, gs_gain);
            end
        end else if (rx_ok) begin
            // TO inside 85 deg, FROM beyond 95 deg folded about pi, OFF between
            if (brg >= -T85 && brg <= T85) begin
                r.flag = FLAG_TO;
            end else if (brg < -T95) begin
                brg    = -PI_Q - brg;
                r.flag = FLAG_FROM;
            end else if (brg > T95) begin
                brg    = PI_Q - brg;
                r.flag = FLAG_FROM;
            end
            course_tgt = scaled_deflection(brg, vor_gain);
        end
        course_last = slew_toward(course_tgt, course_last);
        slope_last  = slew_toward(slope_tgt, slope_last);
        r.course = course_last[PTR_W-1:0];
        r.slope  = slope_last[PTR_W-1:0];
        r.nav_ok = rx_ok;
        r.gs_ok  = rx_ok & ils;
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_indication exp_ind;
        if (!i_rst_n) begin
            loc_gain    = ILS_COURSE_GAIN_RST;
            gs_gain     = ILS_SLOPE_GAIN_RST;
            vor_gain    = VOR_COURSE_GAIN_RST;
            ptr_lim     = POINTER_LIMIT_RST;
            course_last = 0;
            slope_last  = 0;
            due_indications.delete();
        end else begin
            // output word against the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_indications.size() == 0) begin
                    $display("%0t: output word %h/%h with none expected, expected nothing",
                             $time, m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end else begin
                    exp_ind = due_indications.pop_front();
                    check_field("course_pointer", exp_ind.course,
                                $signed(m_axis_tdata[7:0]));
                    check_field("slope_pointer", exp_ind.slope,
                                $signed(m_axis_tdata[15:8]));
                    check_field("direction_flag", exp_ind.flag, m_axis_tuser[1:0]);
                    check_field("nav_valid", exp_ind.nav_ok, m_axis_tuser[2]);
                    check_field("slope_valid", exp_ind.gs_ok, m_axis_tuser[3]);
                end
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_ILS_COURSE_GAIN: loc_gain = i_cfg_data;
                    REG_ILS_SLOPE_GAIN:  gs_gain  = i_cfg_data;
                    REG_VOR_COURSE_GAIN: vor_gain = i_cfg_data;
                    REG_POINTER_LIMIT:   ptr_lim  = i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            // input word
            if (s_axis_tvalid && s_axis_tready) begin
                due_indications.push_back(next_indication(s_axis_tdata[15:0],
                                                          s_axis_tdata[31:16],
                                                          s_axis_tuser[0], s_axis_tuser[1]));
            end
        end
        o_errors  <= mismatches;
        o_pending <= due_indications.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// Stimulus and verdict for the deviation indicator; checking lives in the
// pointer checker instantiated beside the block.
module tb_top;
    import ndis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 100;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata = '0;   // bearing_error[15:0], slope_error[31:16]
    logic [1:0]           s_axis_tuser = '0;   // ils_mode[0], receiver_valid[1]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;        // course_pointer[7:0], slope_pointer[15:8]
    logic [3:0]           m_axis_tuser;        // direction_flag[1:0], nav_valid[2], slope_valid[3]
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [GAIN_W-1:0]    i_cfg_data = '0;

    int errors;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    nav_deviation_indicator_slew u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ndis_pointer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one input word, with random idle cycles ahead of it
    task automatic send_word(input int brg, input int slp, input bit ils, input bit rx_ok);
        int gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {16'(slp), 16'(brg)};
        s_axis_tuser  <= {rx_ok, ils};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic cfg_write(input t_cfg_reg idx, input logic [GAIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_registers(input logic [GAIN_W-1:0] loc_g, input logic [GAIN_W-1:0] gs_g,
                                 input logic [GAIN_W-1:0] vor_g, input logic [LIM_W-1:0] lim);
        cfg_write(REG_ILS_COURSE_GAIN, loc_g);
        cfg_write(REG_ILS_SLOPE_GAIN, gs_g);
        cfg_write(REG_VOR_COURSE_GAIN, vor_g);
        // upper data bits are ignored for the limit; toggle them anyway
        cfg_write(REG_POINTER_LIMIT, {(GAIN_W - LIM_W)'($urandom), lim});
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every predicted indication has been seen
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // mostly steady tracks that let the pointers slew far, some noise words
    task automatic drive_random(input int count);
        int sent;
        int brg;
        int slp;
        int len;
        bit ils;
        bit rx_ok;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 75) begin
                ils   = 1'($urandom_range(1));
                rx_ok = ($urandom_range(9) != 0);
                case ($urandom_range(3))
                    0:       brg = int'($urandom_range(1200)) - 600;
                    1:       brg = $urandom_range(T85 - 200, T95 + 200);
                    2:       brg = PI_Q - int'($urandom_range(1500));
                    default: brg = $urandom_range(32767);
                endcase
                if ($urandom_range(1)) brg = -brg;
                slp = int'($urandom_range(1200)) - 600;
                len = $urandom_range(4, 70);
                for (int k = 0; k < len && sent < count; k++) begin
                    send_word(brg + int'($urandom_range(40)) - 20,
                              slp + int'($urandom_range(40)) - 20, ils, rx_ok);
                    sent++;
                    brg += int'($urandom_range(20)) - 10;
                    slp += int'($urandom_range(20)) - 10;
                end
            end else begin
                send_word($urandom, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: ILS extremes, out-of-range errors, receiver invalid
        send_word(PI_Q, PI_Q, 1, 1);
        send_word(-PI_Q, -PI_Q, 1, 1);
        send_word(0, 0, 1, 1);
        send_word(32767, -32768, 1, 1);
        send_word(-32768, 32767, 1, 1);
        send_word(300, -300, 1, 1);
        send_word(PI_Q, -PI_Q, 1, 0);
        // VOR: TO boundaries, OFF band, FROM fold, extremes, receiver invalid
        send_word(T85, 500, 0, 1);
        send_word(-T85, 500, 0, 1);
        send_word(T85 + 1, 0, 0, 1);
        send_word(-T85 - 1, 0, 0, 1);
        send_word(T95, 0, 0, 1);
        send_word(-T95, 0, 0, 1);
        send_word(T95 + 1, 0, 0, 1);
        send_word(-T95 - 1, 0, 0, 1);
        send_word(PI_Q, 0, 0, 1);
        send_word(-PI_Q, 0, 0, 1);
        send_word(32767, 0, 0, 1);
        send_word(-32768, 0, 0, 1);
        send_word(0, 0, 0, 1);
        send_word(1000, 1000, 0, 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                1: set_registers('1, '1, '1, 7'd127);
                2: set_registers('0, '0, GAIN_W'($urandom), 7'd1);
                3: set_registers(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom), 7'd0);
                4: set_registers(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                                 LIM_W'($urandom_range(1, 127)));
                5: set_registers(GAIN_W'($urandom_range(40000, 400000)),
                                 GAIN_W'($urandom_range(40000, 400000)),
                                 GAIN_W'($urandom_range(20000, 200000)),
                                 LIM_W'($urandom_range(1, 127)));
                default: ;
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 62; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 62; end
                default: begin idle_pct = 9; stall_pct <= 9; end
            endcase
            drive_random(PHASE_WORDS);
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ndis_pkg.sv
hw/rtl/ndis_slew.sv
hw/rtl/nav_deviation_indicator_slew.sv
tb/sv/ndis_pointer_checker.sv
tb/sv/tb_top.sv
